>>> design/srld_pkg.sv
// ----------------------------------------------------------------------------
// S-record line decoder package
// Shared types, character codes and the hex digit decode.
// ----------------------------------------------------------------------------
package srld_pkg;

  typedef enum logic [2:0] {
    PH_S,
    PH_TYPE,
    PH_LEN,
    PH_ADDR,
    PH_DATA,
    PH_CSUM,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NODATA = 2'd1,
    ST_FORMAT = 2'd2,
    ST_LENGTH = 2'd3
  } status_t;

  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  status;
    logic [7:0]  byte_count;
    logic        last;
  } result_t;

  // Results caused by one accepted character: an optional write followed by
  // an optional status.
  typedef struct packed {
    logic        wr_valid;
    logic [31:0] wr_address;
    logic [7:0]  wr_data;
    logic        st_valid;
    logic [1:0]  st_status;
    logic [7:0]  st_count;
  } step_out_t;

  // Returns {valid, value} for one ASCII hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

>>> design/srld_parser.sv
// ----------------------------------------------------------------------------
// S-record parser
// Holds the per-line parse state and works out the results of one character.
// ----------------------------------------------------------------------------
module srld_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            ch,
  input  logic                  line_last,
  output srld_pkg::step_out_t   step_out
);

  srld_pkg::phase_t phase, phase_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        nibble_pending, nibble_pending_next;
  logic [7:0]  remaining, remaining_next;
  logic [2:0]  address_bytes_left, address_bytes_left_next;
  logic [31:0] address, address_next;
  logic [7:0]  data_index, data_index_next;
  logic [7:0]  running_sum, running_sum_next;

  logic [4:0]  hex;
  logic [7:0]  b;
  logic [7:0]  rem_dec;

  always_comb begin
    hex     = srld_pkg::hex_decode(ch);
    b       = {high_nibble, hex[3:0]};
    rem_dec = remaining - 8'd1;

    phase_next              = phase;
    high_nibble_next        = high_nibble;
    nibble_pending_next     = nibble_pending;
    remaining_next          = remaining;
    address_bytes_left_next = address_bytes_left;
    address_next            = address;
    data_index_next         = data_index;
    running_sum_next        = running_sum;

    step_out            = '0;

    unique case (phase)
      srld_pkg::PH_S: begin
        if (ch == srld_pkg::CH_S) begin
          phase_next = srld_pkg::PH_TYPE;
        end else begin
          step_out.st_valid  = 1'b1;
          step_out.st_status = srld_pkg::ST_FORMAT;
        end
      end
      srld_pkg::PH_TYPE: begin
        if (ch >= srld_pkg::CH_ONE && ch <= srld_pkg::CH_THREE) begin
          address_bytes_left_next = {1'b0, ch[1:0]} + 3'd1;
          running_sum_next        = 8'd0;
          nibble_pending_next     = 1'b0;
          address_next            = 32'd0;
          data_index_next         = 8'd0;
          phase_next              = srld_pkg::PH_LEN;
        end else if (ch == srld_pkg::CH_ZERO ||
                     (ch >= srld_pkg::CH_FIVE && ch <= srld_pkg::CH_NINE)) begin
          step_out.st_valid  = 1'b1;
          step_out.st_status = srld_pkg::ST_NODATA;
        end else begin
          step_out.st_valid  = 1'b1;
          step_out.st_status = srld_pkg::ST_FORMAT;
        end
      end
      srld_pkg::PH_LEN, srld_pkg::PH_ADDR, srld_pkg::PH_DATA, srld_pkg::PH_CSUM: begin
        if (!hex[4]) begin
          step_out.st_valid  = 1'b1;
          step_out.st_status = srld_pkg::ST_FORMAT;
        end else if (!nibble_pending) begin
          high_nibble_next    = hex[3:0];
          nibble_pending_next = 1'b1;
        end else begin
          nibble_pending_next = 1'b0;
          running_sum_next    = running_sum + b;
          unique case (phase)
            srld_pkg::PH_LEN: begin
              if (b < {5'd0, address_bytes_left}) begin
                step_out.st_valid  = 1'b1;
                step_out.st_status = srld_pkg::ST_FORMAT;
              end else begin
                remaining_next = b - {5'd0, address_bytes_left};
                phase_next     = srld_pkg::PH_ADDR;
              end
            end
            srld_pkg::PH_ADDR: begin
              address_next            = {address[23:0], b};
              address_bytes_left_next = address_bytes_left - 3'd1;
              if (address_bytes_left == 3'd1) begin
                if (remaining == 8'd0) begin
                  step_out.st_valid  = 1'b1;
                  step_out.st_status = srld_pkg::ST_LENGTH;
                end else begin
                  remaining_next = rem_dec;
                  phase_next = (rem_dec != 8'd0) ? srld_pkg::PH_DATA : srld_pkg::PH_CSUM;
                end
              end
            end
            srld_pkg::PH_DATA: begin
              step_out.wr_valid   = 1'b1;
              step_out.wr_address = address + {24'd0, data_index};
              step_out.wr_data    = b;
              data_index_next     = data_index + 8'd1;
              remaining_next      = rem_dec;
              if (rem_dec == 8'd0) begin
                phase_next = srld_pkg::PH_CSUM;
              end
            end
            default: begin
              step_out.st_valid = 1'b1;
              if (b == ~running_sum) begin
                step_out.st_status = srld_pkg::ST_OK;
                step_out.st_count  = data_index;
              end else begin
                step_out.st_status = srld_pkg::ST_FORMAT;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (step_out.st_valid) begin
      phase_next = srld_pkg::PH_DONE;
    end

    if (line_last) begin
      if (phase_next != srld_pkg::PH_DONE) begin
        step_out.st_valid  = 1'b1;
        step_out.st_status = srld_pkg::ST_FORMAT;
        step_out.st_count  = 8'd0;
      end
      phase_next              = srld_pkg::PH_S;
      high_nibble_next        = 4'd0;
      nibble_pending_next     = 1'b0;
      remaining_next          = 8'd0;
      address_bytes_left_next = 3'd0;
      address_next            = 32'd0;
      data_index_next         = 8'd0;
      running_sum_next        = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= srld_pkg::PH_S;
      high_nibble        <= 4'd0;
      nibble_pending     <= 1'b0;
      remaining          <= 8'd0;
      address_bytes_left <= 3'd0;
      address            <= 32'd0;
      data_index         <= 8'd0;
      running_sum        <= 8'd0;
    end else if (step) begin
      phase              <= phase_next;
      high_nibble        <= high_nibble_next;
      nibble_pending     <= nibble_pending_next;
      remaining          <= remaining_next;
      address_bytes_left <= address_bytes_left_next;
      address            <= address_next;
      data_index         <= data_index_next;
      running_sum        <= running_sum_next;
    end
  end

endmodule

>>> design/srld_result_queue.sv
// ----------------------------------------------------------------------------
// S-record result queue
// Four-entry queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module srld_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  srld_pkg::step_out_t  step_out,
  output logic                 room,
  output logic                 result_valid,
  input  logic                 result_ready,
  output srld_pkg::result_t    head
);

  srld_pkg::result_t entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic [1:0] push_n;
  logic       pop;
  srld_pkg::result_t wr_res, st_res;

  always_comb begin
    wr_res               = '0;
    wr_res.kind          = srld_pkg::KIND_WRITE;
    wr_res.write_address = step_out.wr_address;
    wr_res.write_data    = step_out.wr_data;
    wr_res.last          = !step_out.st_valid;

    st_res            = '0;
    st_res.kind       = srld_pkg::KIND_STATUS;
    st_res.status     = step_out.st_status;
    st_res.byte_count = step_out.st_count;
    st_res.last       = 1'b1;

    push_n = push ? ({1'b0, step_out.wr_valid} + {1'b0, step_out.st_valid}) : 2'd0;
    pop    = result_valid && result_ready;
    count_next = count + {1'b0, push_n} - {2'd0, pop};
  end

  assign room         = (count <= 3'd2);
  assign result_valid = (count != 3'd0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      if (step_out.wr_valid) begin
        entries[wr_ptr] <= wr_res;
        if (step_out.st_valid) begin
          entries[wr_ptr + 2'd1] <= st_res;
        end
      end else if (step_out.st_valid) begin
        entries[wr_ptr] <= st_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

endmodule

>>> design/srecord_line_decoder.sv
// ----------------------------------------------------------------------------
// S-record line decoder
// Parses Motorola S-record lines one character per item into byte writes
// and a record status.
// ----------------------------------------------------------------------------
// The input channel (item_valid/item_ready) carries one ASCII character per
// item, with line_last marking the final character of a line. The output
// channel (result_valid/result_ready) carries results: a byte write (kind 0)
// or a record status (kind 1); last marks the final result of an item.
// One item is accepted per cycle while the queue has room. Its results are
// written into a four-entry queue at the accepting edge, so the first result
// is offered in the next cycle. A truncated line can make two results from
// one item, which the queue drains at one result per cycle with result_ready.
// item_ready is high while the queue has room for two results; a stalled
// receiver fills the queue and then holds off input, losing nothing.
// Reset empties the queue and returns the parser to the start of a line.
// ----------------------------------------------------------------------------
module srecord_line_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  ch,
  input  logic        line_last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        kind,
  output logic [31:0] write_address,
  output logic [7:0]  write_data,
  output logic [1:0]  status,
  output logic [7:0]  byte_count,
  output logic        last
);

  logic                step;
  logic                room;
  srld_pkg::step_out_t step_out;
  srld_pkg::result_t   head;

  assign item_ready = room;
  assign step       = item_valid && room;

  srld_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .ch        (ch),
    .line_last (line_last),
    .step_out  (step_out)
  );

  srld_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (step),
    .step_out     (step_out),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head)
  );

  assign kind          = head.kind;
  assign write_address = head.write_address;
  assign write_data    = head.write_data;
  assign status        = head.status;
  assign byte_count    = head.byte_count;
  assign last          = head.last;

endmodule
